[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a cause is followed by an effect in the next cycle.
`define ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

[sv/spq_pkg.sv]
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int unsigned SPQ_DEPTH = 16;
    localparam int unsigned PRIO_W    = 8;
    localparam int unsigned TAG_W     = 16;
    localparam int unsigned OCC_W     = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Command broadcast to every cell in the chain
    typedef struct packed {
        logic              insert;
        logic              remove;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } spq_cmd_t;

endpackage

[sv/stable_priority_queue.sv]
// ---------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue held sorted in a chain of cells; lower priority
// values leave first, equal values leave in arrival order.
// ---------------------------------------------------------------------------
//  channel  signals                                  direction
//  request  req_valid req_stall kind priority_req    in  (stall out)
//           payload
//  response rsp_valid rsp_stall status out_priority  out (stall in)
//           out_payload occupancy
//
//  One request per cycle while not stalled: every cell compares against the
//  new key at once and the whole chain shifts in the same edge. The response
//  appears in the cycle after its request transfer, in an output register. A
//  request is stalled only while a response waits and rsp_stall is high. Reset
//  empties the queue at once; cell contents need no clearing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned DEPTH = SPQ_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              kind,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [TAG_W-1:0]  payload,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [1:0]        status,
    output logic [PRIO_W-1:0] out_priority,
    output logic [TAG_W-1:0]  out_payload,
    output logic [OCC_W-1:0]  occupancy
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [PRIO_W-1:0] out_prio_reg;
    logic [PRIO_W-1:0] out_prio_next;
    logic [TAG_W-1:0]  out_tag_reg;
    logic [TAG_W-1:0]  out_tag_next;

    logic              accept;
    logic              full;
    logic              empty;
    spq_cmd_t          cmd;

    logic [DEPTH-1:0]  cell_sel;
    logic [DEPTH-1:0]  cell_occ;
    logic [PRIO_W-1:0] cell_prio [DEPTH];
    logic [TAG_W-1:0]  cell_tag  [DEPTH];
    logic [CNT_W+OCC_W-1:0] count_ext;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    assign cmd.insert = accept && (kind == KIND_INSERT) && !full;
    assign cmd.remove = accept && (kind == KIND_REMOVE) && !empty;
    assign cmd.prio   = priority_req;
    assign cmd.tag    = payload;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic              l_sel;
            logic [PRIO_W-1:0] l_prio;
            logic [TAG_W-1:0]  l_tag;
            logic [PRIO_W-1:0] r_prio;
            logic [TAG_W-1:0]  r_tag;

            assign cell_occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign l_sel  = 1'b0;
                assign l_prio = cell_prio[gi];
                assign l_tag  = cell_tag[gi];
            end
            else
            begin : g_body
                assign l_sel  = cell_sel[gi-1];
                assign l_prio = cell_prio[gi-1];
                assign l_tag  = cell_tag[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_prio = cell_prio[gi];
                assign r_tag  = cell_tag[gi];
            end
            else
            begin : g_link
                assign r_prio = cell_prio[gi+1];
                assign r_tag  = cell_tag[gi+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .occupied   (cell_occ[gi]),
                .cmd        (cmd),
                .left_sel   (l_sel),
                .left_prio  (l_prio),
                .left_tag   (l_tag),
                .right_prio (r_prio),
                .right_tag  (r_tag),
                .sel        (cell_sel[gi]),
                .prio       (cell_prio[gi]),
                .tag        (cell_tag[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        out_prio_next  = out_prio_reg;
        out_tag_next   = out_tag_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = ST_DONE;
            out_prio_next  = '0;
            out_tag_next   = '0;
            unique case (kind)
                KIND_INSERT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                KIND_REMOVE:
                begin
                    if (empty)
                        status_next = ST_EMPTY;
                    else
                    begin
                        count_next    = count_reg - CNT_W'(1);
                        out_prio_next = cell_prio[0];
                        out_tag_next  = cell_tag[0];
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            out_prio_reg <= out_prio_next;
            out_tag_reg  <= out_tag_next;
        end
    end

    // Occupancy reports the count after the transfer, taken modulo 32
    logic [OCC_W-1:0] occ_hold_reg;
    assign count_ext = {{OCC_W{1'b0}}, count_next};

    always_ff @(posedge clk)
    begin
        if (accept)
            occ_hold_reg <= count_ext[OCC_W-1:0];
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign out_priority = out_prio_reg;
    assign out_payload  = out_tag_reg;
    assign occupancy    = occ_hold_reg;

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count exceeds depth")
    `ASSERT_ALWAYS(a_chain_sorted, ((cell_sel << 1) & ~cell_sel) == '0,
        "insert select not monotonic, chain out of order")
    `ASSERT_NEXT(a_rsp_follows, accept, rsp_valid_reg, "request transfer gave no response")
    `ASSERT_NEXT(a_insert_count, cmd.insert, count_reg == $past(count_reg) + CNT_W'(1),
        "insert did not grow the queue")
    `ASSERT_NEXT(a_full_refused, accept && (kind == KIND_INSERT) && full,
        (status_reg == ST_FULL) && (count_reg == CNT_W'(DEPTH)),
        "insert into full queue not refused")

endmodule

[sv/spq_cell.sv]
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, shifts toward the tail on
// insert and toward the head on remove.
// ---------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic              clk,
    input  logic              occupied,
    input  spq_cmd_t          cmd,
    input  logic              left_sel,
    input  logic [PRIO_W-1:0] left_prio,
    input  logic [TAG_W-1:0]  left_tag,
    input  logic [PRIO_W-1:0] right_prio,
    input  logic [TAG_W-1:0]  right_tag,
    output logic              sel,
    output logic [PRIO_W-1:0] prio,
    output logic [TAG_W-1:0]  tag
);

    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [TAG_W-1:0]  tag_reg;
    logic [TAG_W-1:0]  tag_next;

    // Slot lies at or behind the insert point
    assign sel  = !occupied || (prio_reg > cmd.prio);
    assign prio = prio_reg;
    assign tag  = tag_reg;

    always_comb
    begin
        prio_next = prio_reg;
        tag_next  = tag_reg;
        priority if (cmd.insert && sel)
        begin
            if (left_sel)
            begin
                prio_next = left_prio;
                tag_next  = left_tag;
            end
            else
            begin
                prio_next = cmd.prio;
                tag_next  = cmd.tag;
            end
        end
        else if (cmd.remove)
        begin
            prio_next = right_prio;
            tag_next  = right_tag;
        end
        else
        begin
            // hold
            prio_next = prio_reg;
            tag_next  = tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

endmodule

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for stable_priority_queue. A directed table covers the
// empty and full refusals, the extreme keys and payloads, and stable order
// among equal keys. Random bursts then fill and drain the queue with
// insert-heavy, remove-heavy and mixed traffic under random gaps and stalls.
// Each response is checked per field against a fixed row or a store model.
// ---------------------------------------------------------------------------
module tb_top;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 1200;
    localparam int QUIET_LIMIT  = 200;
    localparam int PLAN_LEN     = 23;

    typedef struct packed {
        status_t           status;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic [OCC_W-1:0]  occ;
    } queue_result_t;

    typedef struct packed {
        logic              kind;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
        logic              fixed;
        queue_result_t     want;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    logic              kind;
    logic [PRIO_W-1:0] priority_req;
    logic [TAG_W-1:0]  payload;
    logic              rsp_valid;
    logic              rsp_stall;
    logic [1:0]        status;
    logic [PRIO_W-1:0] out_priority;
    logic [TAG_W-1:0]  out_payload;
    logic [OCC_W-1:0]  occupancy;

    // sorted store model, slot 0 is the head
    logic [PRIO_W-1:0] held_prio [SPQ_DEPTH];
    logic [TAG_W-1:0]  held_tag  [SPQ_DEPTH];
    int                held_count;

    queue_result_t     awaited_results [$];
    plan_row_t         plan [PLAN_LEN];

    int n_errors;
    int n_responses;
    int n_inserts;
    int n_removes;
    int n_full;
    int n_empty;
    int stall_left;
    bit calm;

    stable_priority_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .kind         (kind),
        .priority_req (priority_req),
        .payload      (payload),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .out_priority (out_priority),
        .out_payload  (out_payload),
        .occupancy    (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic queue_result_t apply_request(logic k, logic [PRIO_W-1:0] p,
                                                    logic [TAG_W-1:0] t);
        queue_result_t r;
        int            pos;
        int            j;
        r = '{ST_DONE, 8'h00, 16'h0000, 5'd0};
        if (k == KIND_INSERT)
        begin
            if (held_count >= SPQ_DEPTH)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                // land after every entry with an equal or smaller key
                pos = held_count;
                for (j = held_count - 1; j >= 0; j--)
                    if (held_prio[j] > p)
                        pos = j;
                for (j = held_count; j > pos; j--)
                begin
                    held_prio[j] = held_prio[j-1];
                    held_tag[j]  = held_tag[j-1];
                end
                held_prio[pos] = p;
                held_tag[pos]  = t;
                held_count++;
                n_inserts++;
            end
        end
        else if (held_count == 0)
        begin
            r.status = ST_EMPTY;
            n_empty++;
        end
        else
        begin
            r.prio = held_prio[0];
            r.tag  = held_tag[0];
            for (j = 1; j < held_count; j++)
            begin
                held_prio[j-1] = held_prio[j];
                held_tag[j-1]  = held_tag[j];
            end
            held_count--;
            n_removes++;
        end
        r.occ = held_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("response %0d: %s is %0d, expected %0d", n_responses, field, got, want);
        n_errors++;
    endtask

    // Hold the request until transfer, then log what it must produce.
    task automatic send_request(logic k, logic [PRIO_W-1:0] p, logic [TAG_W-1:0] t,
                                logic fixed, queue_result_t typed);
        int            gap;
        queue_result_t r;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        kind         <= k;
        priority_req <= p;
        payload      <= t;
        do
            @(posedge clk);
        while (!(req_valid && !req_stall));
        r = apply_request(k, p, t);
        awaited_results.push_back(fixed ? typed : r);
    endtask

    // Response side: stall after transfers and now and then while idle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!rsp_stall)
            begin
                if (!calm && (rsp_valid || $urandom_range(0, 3) == 0))
                begin
                    stall_left = $urandom_range(0, 4);
                    if (stall_left > 0)
                        rsp_stall <= 1'b1;
                end
            end
            else
            begin
                stall_left--;
                if (stall_left <= 0)
                    rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            n_responses++;
            if (awaited_results.size() == 0)
            begin
                $display("response %0d arrived with nothing outstanding", n_responses);
                n_errors++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status != want.status)
                    report_mismatch("status", status, want.status);
                if (out_priority != want.prio)
                    report_mismatch("out_priority", out_priority, want.prio);
                if (out_payload != want.tag)
                    report_mismatch("out_payload", out_payload, want.tag);
                if (occupancy != want.occ)
                    report_mismatch("occupancy", occupancy, want.occ);
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("[stable_priority_queue] ERROR");
        $finish;
    end

    initial
    begin
        int            i;
        int            sent;
        int            burst;
        int            mode;
        bit            narrow;
        logic          k;
        logic [PRIO_W-1:0] p;
        queue_result_t none;

        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        kind         <= KIND_INSERT;
        priority_req <= '0;
        payload      <= '0;
        rsp_stall    <= 1'b0;
        held_count   = 0;
        n_errors     = 0;
        n_responses  = 0;
        n_inserts    = 0;
        n_removes    = 0;
        n_full       = 0;
        n_empty      = 0;
        stall_left   = 0;
        calm         = 1'b0;
        none         = '{ST_DONE, 8'h00, 16'h0000, 5'd0};

        // empty refusal, extremes, ignored fields on remove
        plan[0]  = '{KIND_REMOVE, 8'h00, 16'h0000, 1'b1, '{ST_EMPTY, 8'h00, 16'h0000, 5'd0}};
        plan[1]  = '{KIND_INSERT, 8'hFF, 16'hFFFF, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd1}};
        plan[2]  = '{KIND_INSERT, 8'h00, 16'h0000, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd2}};
        plan[3]  = '{KIND_REMOVE, 8'hFF, 16'hFFFF, 1'b1, '{ST_DONE, 8'h00, 16'h0000, 5'd1}};
        plan[4]  = '{KIND_REMOVE, 8'hAA, 16'h5555, 1'b1, '{ST_DONE, 8'hFF, 16'hFFFF, 5'd0}};
        // fill with repeated keys to exercise arrival order among equals
        plan[5]  = '{KIND_INSERT, 8'd7,   16'h1000, 1'b0, none};
        plan[6]  = '{KIND_INSERT, 8'd7,   16'h1001, 1'b0, none};
        plan[7]  = '{KIND_INSERT, 8'd3,   16'h1002, 1'b0, none};
        plan[8]  = '{KIND_INSERT, 8'd255, 16'h1003, 1'b0, none};
        plan[9]  = '{KIND_INSERT, 8'd0,   16'h1004, 1'b0, none};
        plan[10] = '{KIND_INSERT, 8'd7,   16'h1005, 1'b0, none};
        plan[11] = '{KIND_INSERT, 8'd3,   16'h1006, 1'b0, none};
        plan[12] = '{KIND_INSERT, 8'd128, 16'h1007, 1'b0, none};
        plan[13] = '{KIND_INSERT, 8'd0,   16'h1008, 1'b0, none};
        plan[14] = '{KIND_INSERT, 8'd255, 16'h1009, 1'b0, none};
        plan[15] = '{KIND_INSERT, 8'd7,   16'h100A, 1'b0, none};
        plan[16] = '{KIND_INSERT, 8'd1,   16'h100B, 1'b0, none};
        plan[17] = '{KIND_INSERT, 8'd254, 16'h100C, 1'b0, none};
        plan[18] = '{KIND_INSERT, 8'd7,   16'h100D, 1'b0, none};
        plan[19] = '{KIND_INSERT, 8'd0,   16'h100E, 1'b0, none};
        plan[20] = '{KIND_INSERT, 8'd255, 16'h100F, 1'b0, none};
        // full refusal, then drain one
        plan[21] = '{KIND_INSERT, 8'h00, 16'hFFFF, 1'b1, '{ST_FULL, 8'h00, 16'h0000, 5'd16}};
        plan[22] = '{KIND_REMOVE, 8'h00, 16'h0000, 1'b0, none};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PLAN_LEN; i++)
            send_request(plan[i].kind, plan[i].prio, plan[i].tag, plan[i].fixed,
                         plan[i].want);

        // bursts that push the queue toward full or empty
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst  = $urandom_range(4, 40);
            mode   = $urandom_range(0, 2);
            narrow = $urandom_range(0, 1);
            calm   = ($urandom_range(0, 3) == 0);
            for (i = 0; i < burst; i++)
            begin
                case (mode)
                    0:       k = ($urandom_range(0, 9) < 2) ? KIND_REMOVE : KIND_INSERT;
                    1:       k = ($urandom_range(0, 9) < 8) ? KIND_REMOVE : KIND_INSERT;
                    default: k = ($urandom_range(0, 1) == 1) ? KIND_REMOVE : KIND_INSERT;
                endcase
                case ($urandom_range(0, 9))
                    0:       p = 8'h00;
                    1:       p = 8'hFF;
                    default: p = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
                endcase
                send_request(k, p, 16'($urandom_range(0, 65535)), 1'b0, none);
                sent++;
            end
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d responses checked: %0d inserts, %0d removes done", n_responses,
                 n_inserts, n_removes);
        $display("refused %0d inserts on a full queue, %0d removes on an empty one",
                 n_full, n_empty);
        if (n_errors == 0)
            $display("[stable_priority_queue] OK");
        else
            $display("[stable_priority_queue] ERROR");
        $finish;
    end

endmodule
